@@ rtl/fdr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and widths for the Fresnel dielectric reflectance block.
// No dependencies.
package fdr_pkg;

  localparam int COS_W     = 16;
  localparam int ETA_W     = 16;
  localparam int REFL_W    = 16;
  localparam int WORK_BITS = 30;
  localparam int Q_W       = WORK_BITS + 1;
  localparam int ETASQ_W   = 2 * ETA_W;
  localparam int LHS_W     = ETASQ_W + Q_W;
  localparam int PROD_W    = ETA_W + Q_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int NORM_W    = 31;
  localparam int QUO_W     = NORM_W + 1;
  localparam int SQ_W      = 2 * QUO_W;
  localparam int SHIFT_W   = 5;
  localparam int OUT_SHIFT = 2 * (QUO_W - 1) - REFL_W + 1;

  localparam logic [ETA_W-1:0] ETA_INCIDENT_RST = 16'd4096;
  localparam logic [ETA_W-1:0] ETA_TRANSMIT_RST = 16'd6144;

  typedef enum logic [0:0] {
    REG_ETA_INCIDENT = 1'b0,
    REG_ETA_TRANSMIT = 1'b1
  } cfg_reg_t;

endpackage

@@ rtl/fdr_in_if.sv @@
`timescale 1ns / 1ps
// Input channel: one cosine item per handshake.
// Depends on fdr_pkg.
interface fdr_in_if import fdr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [COS_W-1:0] cos_incident;

  modport source (output valid, output cos_incident, input ready);
  modport sink (input valid, input cos_incident, output ready);
endinterface

@@ rtl/fdr_out_if.sv @@
`timescale 1ns / 1ps
// Result channel: reflectance and total internal reflection flag.
// Depends on fdr_pkg.
interface fdr_out_if import fdr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REFL_W-1:0] reflectance;
  logic              total_internal;

  modport source (output valid, output reflectance, output total_internal, input ready);
  modport sink (input valid, input reflectance, input total_internal, output ready);
endinterface

@@ rtl/fdr_cfg_if.sv @@
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
// Depends on fdr_pkg.
interface fdr_cfg_if import fdr_pkg::*; ();
  logic             valid;
  logic             ready;
  cfg_reg_t         index;
  logic [ETA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/fresnel_dielectric_reflectance.sv @@
`timescale 1ns / 1ps
// Unpolarized Fresnel reflectance of a smooth dielectric boundary, top level.
// Depends on fdr_pkg, the fdr_*_if interfaces, fdr_divpipe and fdr_sqrtpipe.
//
// Usage:
//   in_ch carries one signed Q2.14 cosine per item; out_ch returns one item per
//   input: Q0.16 reflectance and the total internal reflection flag, in order.
//   cfg_ch writes eta_incident (index 0) and eta_transmit (index 1), Q4.12; it
//   is always ready. The user must write it only while the pipeline is empty;
//   the block has no check for it. The pipeline has 103 register stages, from
//   the first local stage to the output register: 10 local stages, 30 stages
//   of the sine divider, 31 of the square root and 32 of the two amplitude
//   dividers running side by side.
//   Throughput is one item per cycle; in_ch.ready is high whenever the output
//   register is empty or being taken.
//   When the receiver stalls, the whole pipeline holds in place and the result
//   waits in the output register; nothing is dropped or repeated.
//   Reset empties the pipeline and loads the index registers with 1.0 and 1.5.
module fresnel_dielectric_reflectance import fdr_pkg::*; #(
  parameter int COS_FRAC_BITS = 14
) (
  input  logic       clk,
  input  logic       rst_n,
  fdr_in_if.sink     in_ch,
  fdr_out_if.source  out_ch,
  fdr_cfg_if.sink    cfg_ch
);

  localparam int                CQ_SHIFT = WORK_BITS - COS_FRAC_BITS;
  localparam logic signed [31:0] ONE     = 32'sd1 <<< COS_FRAC_BITS;
  localparam int                SIDE_W   = 1 + Q_W + 2 * ETA_W;

  function automatic logic [SHIFT_W-1:0] norm_shift(input logic [SUM_W-1:0] d);
    logic [SHIFT_W-1:0] s;
    s = '0;
    for (int b = NORM_W; b < SUM_W; b++) begin
      if (d[b]) begin
        s = SHIFT_W'(b - NORM_W + 1);
      end
    end
    return s;
  endfunction

  logic en;

  logic [ETA_W-1:0] eta_incident_r;
  logic [ETA_W-1:0] eta_transmit_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eta_incident_r <= ETA_INCIDENT_RST;
      eta_transmit_r <= ETA_TRANSMIT_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_ETA_INCIDENT: eta_incident_r <= cfg_ch.data;
        REG_ETA_TRANSMIT: eta_transmit_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // clamp, swap
  logic signed [31:0] c_ext;
  logic signed [31:0] c_clamp;
  logic               c_pos;
  logic [15:0]        c_mag;
  logic [ETA_W-1:0]   ei_eff;
  logic [ETA_W-1:0]   et_eff;

  always_comb begin
    c_ext = {{(32 - COS_W){in_ch.cos_incident[COS_W-1]}}, in_ch.cos_incident};
    if (c_ext > ONE) begin
      c_clamp = ONE;
    end else if (c_ext < -ONE) begin
      c_clamp = -ONE;
    end else begin
      c_clamp = c_ext;
    end
    c_pos  = (c_clamp > 32'sd0);
    c_mag  = c_pos ? c_clamp[15:0] : 16'(-c_clamp);
    ei_eff = (eta_incident_r == '0) ? ETA_W'(1) : eta_incident_r;
    et_eff = (eta_transmit_r == '0) ? ETA_W'(1) : eta_transmit_r;
  end

  logic             vld_s1_r;
  logic [Q_W-1:0]   cq_s1_r;
  logic [ETA_W-1:0] ei_s1_r;
  logic [ETA_W-1:0] et_s1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cq_s1_r <= {15'b0, c_mag} << CQ_SHIFT;
      ei_s1_r <= c_pos ? ei_eff : et_eff;
      et_s1_r <= c_pos ? et_eff : ei_eff;
    end
  end

  // squares
  logic               vld_s2_r;
  logic [2*Q_W-1:0]   cqsq_s2_r;
  logic [ETASQ_W-1:0] eisq_s2_r;
  logic [ETASQ_W-1:0] etsq_s2_r;
  logic [Q_W-1:0]     cq_s2_r;
  logic [ETA_W-1:0]   ei_s2_r;
  logic [ETA_W-1:0]   et_s2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cqsq_s2_r <= cq_s1_r * cq_s1_r;
      eisq_s2_r <= ei_s1_r * ei_s1_r;
      etsq_s2_r <= et_s1_r * et_s1_r;
      cq_s2_r   <= cq_s1_r;
      ei_s2_r   <= ei_s1_r;
      et_s2_r   <= et_s1_r;
    end
  end

  // incident sine squared
  logic [2*WORK_BITS:0] sin2i_full;
  assign sin2i_full = ((2*WORK_BITS+1)'(1) << (2 * WORK_BITS))
                    - (2*WORK_BITS+1)'(cqsq_s2_r);

  logic               vld_s3_r;
  logic [Q_W-1:0]     sin2i_s3_r;
  logic [ETASQ_W-1:0] eisq_s3_r;
  logic [ETASQ_W-1:0] etsq_s3_r;
  logic [Q_W-1:0]     cq_s3_r;
  logic [ETA_W-1:0]   ei_s3_r;
  logic [ETA_W-1:0]   et_s3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sin2i_s3_r <= sin2i_full[2*WORK_BITS -: Q_W];
      eisq_s3_r  <= eisq_s2_r;
      etsq_s3_r  <= etsq_s2_r;
      cq_s3_r    <= cq_s2_r;
      ei_s3_r    <= ei_s2_r;
      et_s3_r    <= et_s2_r;
    end
  end

  logic               vld_s4_r;
  logic [LHS_W-1:0]   lhs_s4_r;
  logic [ETASQ_W-1:0] etsq_s4_r;
  logic [Q_W-1:0]     cq_s4_r;
  logic [ETA_W-1:0]   ei_s4_r;
  logic [ETA_W-1:0]   et_s4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      lhs_s4_r  <= eisq_s3_r * sin2i_s3_r;
      etsq_s4_r <= etsq_s3_r;
      cq_s4_r   <= cq_s3_r;
      ei_s4_r   <= ei_s3_r;
      et_s4_r   <= et_s3_r;
    end
  end

  // total internal reflection test and transmitted sine squared
  logic              tir_s4;
  logic [SIDE_W-1:0] div1_side;
  logic              div1_vld;
  logic [WORK_BITS-1:0] sin2t;
  logic [SIDE_W-1:0] div1_side_out;

  assign tir_s4    = (lhs_s4_r >= LHS_W'({etsq_s4_r, {WORK_BITS{1'b0}}}));
  assign div1_side = {tir_s4, cq_s4_r, ei_s4_r, et_s4_r};

  fdr_divpipe #(
    .NW(LHS_W), .DW(ETASQ_W), .QW(WORK_BITS), .SW(SIDE_W)
  ) u_sin_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(vld_s4_r), .in_num(lhs_s4_r), .in_den(etsq_s4_r), .in_side(div1_side),
    .out_valid(div1_vld), .out_quo(sin2t), .out_side(div1_side_out)
  );

  // transmitted cosine
  logic [Q_W-1:0]     cos2t;
  logic [2*Q_W-1:0]   rad;
  logic               sqrt_vld;
  logic [Q_W-1:0]     ct;
  logic [SIDE_W-1:0]  sqrt_side;

  assign cos2t = (Q_W'(1) << WORK_BITS) - Q_W'(sin2t);
  assign rad   = {1'b0, cos2t, {WORK_BITS{1'b0}}};

  fdr_sqrtpipe #(
    .RW(Q_W), .SW(SIDE_W)
  ) u_cos_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(div1_vld), .in_rad(rad), .in_side(div1_side_out),
    .out_valid(sqrt_vld), .out_root(ct), .out_side(sqrt_side)
  );

  logic             tir_s5;
  logic [Q_W-1:0]   cq_s5;
  logic [ETA_W-1:0] ei_s5;
  logic [ETA_W-1:0] et_s5;

  assign {tir_s5, cq_s5, ei_s5, et_s5} = sqrt_side;

  // amplitude products
  logic              vld_s6_r;
  logic              tir_s6_r;
  logic [PROD_W-1:0] xa_s6_r;
  logic [PROD_W-1:0] ya_s6_r;
  logic [PROD_W-1:0] xb_s6_r;
  logic [PROD_W-1:0] yb_s6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      tir_s6_r <= tir_s5;
      xa_s6_r  <= et_s5 * cq_s5;
      ya_s6_r  <= ei_s5 * ct;
      xb_s6_r  <= ei_s5 * cq_s5;
      yb_s6_r  <= et_s5 * ct;
    end
  end

  logic             vld_s7_r;
  logic             tir_s7_r;
  logic [SUM_W-1:0] numa_s7_r;
  logic [SUM_W-1:0] dena_s7_r;
  logic [SUM_W-1:0] numb_s7_r;
  logic [SUM_W-1:0] denb_s7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      tir_s7_r  <= tir_s6_r;
      numa_s7_r <= SUM_W'((xa_s6_r > ya_s6_r) ? (xa_s6_r - ya_s6_r) : (ya_s6_r - xa_s6_r));
      dena_s7_r <= SUM_W'(xa_s6_r) + SUM_W'(ya_s6_r);
      numb_s7_r <= SUM_W'((xb_s6_r > yb_s6_r) ? (xb_s6_r - yb_s6_r) : (yb_s6_r - xb_s6_r));
      denb_s7_r <= SUM_W'(xb_s6_r) + SUM_W'(yb_s6_r);
    end
  end

  logic               vld_s8_r;
  logic               tir_s8_r;
  logic [SHIFT_W-1:0] sha_s8_r;
  logic [SHIFT_W-1:0] shb_s8_r;
  logic [SUM_W-1:0]   numa_s8_r;
  logic [SUM_W-1:0]   dena_s8_r;
  logic [SUM_W-1:0]   numb_s8_r;
  logic [SUM_W-1:0]   denb_s8_r;

  always_ff @(posedge clk) begin
    if (en) begin
      tir_s8_r  <= tir_s7_r;
      sha_s8_r  <= norm_shift(dena_s7_r);
      shb_s8_r  <= norm_shift(denb_s7_r);
      numa_s8_r <= numa_s7_r;
      dena_s8_r <= dena_s7_r;
      numb_s8_r <= numb_s7_r;
      denb_s8_r <= denb_s7_r;
    end
  end

  logic              vld_s9_r;
  logic              tir_s9_r;
  logic [NORM_W-1:0] numa_s9_r;
  logic [NORM_W-1:0] dena_s9_r;
  logic [NORM_W-1:0] numb_s9_r;
  logic [NORM_W-1:0] denb_s9_r;

  always_ff @(posedge clk) begin
    if (en) begin
      tir_s9_r  <= tir_s8_r;
      numa_s9_r <= NORM_W'(numa_s8_r >> sha_s8_r);
      dena_s9_r <= NORM_W'(dena_s8_r >> sha_s8_r);
      numb_s9_r <= NORM_W'(numb_s8_r >> shb_s8_r);
      denb_s9_r <= NORM_W'(denb_s8_r >> shb_s8_r);
    end
  end

  // amplitude ratios
  logic             diva_vld;
  logic [QUO_W-1:0] qa;
  logic [QUO_W-1:0] qb;
  logic [1:0]       diva_side;
  logic             divb_side;
  logic             tir_s10;
  logic             za_s10;

  fdr_divpipe #(
    .NW(2 * NORM_W + 1), .DW(NORM_W), .QW(QUO_W), .SW(2)
  ) u_ratio_div_a (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(vld_s9_r), .in_num({1'b0, numa_s9_r, {NORM_W{1'b0}}}), .in_den(dena_s9_r),
    .in_side({tir_s9_r, (dena_s9_r == '0)}),
    .out_valid(diva_vld), .out_quo(qa), .out_side(diva_side)
  );

  fdr_divpipe #(
    .NW(2 * NORM_W + 1), .DW(NORM_W), .QW(QUO_W), .SW(1)
  ) u_ratio_div_b (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(vld_s9_r), .in_num({1'b0, numb_s9_r, {NORM_W{1'b0}}}), .in_den(denb_s9_r),
    .in_side(denb_s9_r == '0),
    .out_valid(), .out_quo(qb), .out_side(divb_side)
  );

  assign {tir_s10, za_s10} = diva_side;

  logic            vld_s10_r;
  logic            tir_s10_r;
  logic [SQ_W-1:0] sqa_s10_r;
  logic [SQ_W-1:0] sqb_s10_r;
  logic [SQ_W-1:0] sqa;
  logic [SQ_W-1:0] sqb;

  assign sqa = qa * qa;
  assign sqb = qb * qb;

  always_ff @(posedge clk) begin
    if (en) begin
      tir_s10_r <= tir_s10;
      sqa_s10_r <= za_s10 ? '0 : sqa;
      sqb_s10_r <= divb_side ? '0 : sqb;
    end
  end

  // mean, round, saturate
  logic [SQ_W-1:0]           sum;
  logic [SQ_W-1:0]           rnd;
  logic [SQ_W-OUT_SHIFT-1:0] r_wide;
  logic [REFL_W-1:0]         r_sat;

  assign sum    = sqa_s10_r + sqb_s10_r;
  assign rnd    = sum + (SQ_W'(1) << (OUT_SHIFT - 1));
  assign r_wide = rnd[SQ_W-1:OUT_SHIFT];
  assign r_sat  = (|r_wide[SQ_W-OUT_SHIFT-1:REFL_W]) ? {REFL_W{1'b1}} : r_wide[REFL_W-1:0];

  logic              out_valid_r;
  logic [REFL_W-1:0] reflectance_r;
  logic              total_internal_r;

  always_ff @(posedge clk) begin
    if (en) begin
      reflectance_r    <= tir_s10_r ? {REFL_W{1'b1}} : r_sat;
      total_internal_r <= tir_s10_r;
    end
  end

  // valid chain of the local stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_s1_r    <= 1'b0;
      vld_s2_r    <= 1'b0;
      vld_s3_r    <= 1'b0;
      vld_s4_r    <= 1'b0;
      vld_s6_r    <= 1'b0;
      vld_s7_r    <= 1'b0;
      vld_s8_r    <= 1'b0;
      vld_s9_r    <= 1'b0;
      vld_s10_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_s1_r    <= in_ch.valid;
      vld_s2_r    <= vld_s1_r;
      vld_s3_r    <= vld_s2_r;
      vld_s4_r    <= vld_s3_r;
      vld_s6_r    <= sqrt_vld;
      vld_s7_r    <= vld_s6_r;
      vld_s8_r    <= vld_s7_r;
      vld_s9_r    <= vld_s8_r;
      vld_s10_r   <= diva_vld;
      out_valid_r <= vld_s10_r;
    end
  end

  assign en                    = !out_valid_r || out_ch.ready;
  assign in_ch.ready           = en;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.reflectance    = reflectance_r;
  assign out_ch.total_internal = total_internal_r;

endmodule

@@ rtl/fdr_divpipe.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Standalone; requires num < den << QW.
module fdr_divpipe #(
  parameter int NW = 63,
  parameter int DW = 32,
  parameter int QW = 30,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic [NW-1:0] rem_r  [QW-1];
  logic [DW-1:0] den_r  [QW-1];
  logic [QW-1:0] quo_r  [QW];
  logic [SW-1:0] side_r [QW];
  logic [QW-1:0] vld_r;

  for (genvar g = 0; g < QW; g++) begin : g_stage
    localparam int K = QW - 1 - g;
    logic [NW-1:0] rem_in;
    logic [NW-1:0] trial;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [SW-1:0] side_in;
    logic          vld_in;
    logic          ge;

    if (g == 0) begin : g_first
      assign rem_in  = in_num;
      assign den_in  = in_den;
      assign quo_in  = '0;
      assign side_in = in_side;
      assign vld_in  = in_valid;
    end else begin : g_next
      assign rem_in  = rem_r[g-1];
      assign den_in  = den_r[g-1];
      assign quo_in  = quo_r[g-1];
      assign side_in = side_r[g-1];
      assign vld_in  = vld_r[g-1];
    end

    assign trial = NW'(den_in) << K;
    assign ge    = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[g]  <= {quo_in[QW-2:0], ge};
        side_r[g] <= side_in;
      end
    end

    if (g < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[g] <= ge ? (rem_in - trial) : rem_in;
          den_r[g] <= den_in;
        end
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quo   = quo_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

@@ rtl/fdr_sqrtpipe.sv @@
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage, with sideband.
// Standalone; gives floor(sqrt(in_rad)).
module fdr_sqrtpipe #(
  parameter int RW = 31,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*RW-1:0] in_rad,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [RW-1:0]   out_root,
  output logic [SW-1:0]   out_side
);

  localparam int XW = 2 * RW;

  logic [XW-1:0] rem_r  [RW-1];
  logic [RW-1:0] root_r [RW];
  logic [SW-1:0] side_r [RW];
  logic [RW-1:0] vld_r;

  for (genvar g = 0; g < RW; g++) begin : g_stage
    localparam int K = RW - 1 - g;
    logic [XW-1:0] rem_in;
    logic [XW-1:0] trial;
    logic [RW-1:0] root_in;
    logic [SW-1:0] side_in;
    logic          vld_in;
    logic          ge;

    if (g == 0) begin : g_first
      assign rem_in  = in_rad;
      assign root_in = '0;
      assign side_in = in_side;
      assign vld_in  = in_valid;
    end else begin : g_next
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
      assign side_in = side_r[g-1];
      assign vld_in  = vld_r[g-1];
    end

    assign trial = (XW'(root_in) << (K + 1)) | (XW'(1) << (2 * K));
    assign ge    = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[g] <= ge ? (root_in | (RW'(1) << K)) : root_in;
        side_r[g] <= side_in;
      end
    end

    if (g < RW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[g] <= ge ? (rem_in - trial) : rem_in;
        end
      end
    end
  end

  assign out_valid = vld_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_side  = side_r[RW-1];

endmodule

@@ rtl/fdr_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the Fresnel reflectance block, bound to the top level.
// Depends on fdr_pkg and fresnel_dielectric_reflectance.
module fdr_checker import fdr_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [REFL_W-1:0] reflectance,
  input logic              total_internal
);

  a_ready_follows_output: assert property (
    @(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready)
  ) else $error("in_ready does not follow the output register state");

  a_stall_holds_item: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(reflectance) && $stable(total_internal)
  ) else $error("stalled result item changed or vanished");

  a_tir_saturates: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid && total_internal |-> reflectance == {REFL_W{1'b1}}
  ) else $error("total internal reflection without full reflectance");

  a_reset_empties: assert property (
    @(posedge clk)
    !rst_n |=> !out_valid
  ) else $error("result valid right after reset");

endmodule

bind fresnel_dielectric_reflectance fdr_checker u_fdr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .reflectance    (out_ch.reflectance),
  .total_internal (out_ch.total_internal)
);
